>>> hw/rtl/wsg_pkg.sv
// wsg_pkg: shared types, register indexes and constants of the waveform sample generator
// no dependencies; imported by the sine rom and the top level
`timescale 1ns / 1ps
`default_nettype none

package wsg_pkg;

  // configuration port shape
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // fixed field widths
  localparam int LEVEL_W = 24;
  localparam int WAVE_W  = 18;  // signed, -1.0 .. +1.0 in Q16
  localparam int ROM_W   = 17;  // unsigned, 0 .. 1.0 in Q16

  // pipeline depth from accept to output register
  localparam int NSTAGE = 8;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_STEP      = 3'd0,
    REG_PHASE_OFFSET_US = 3'd1,
    REG_AMPLITUDE_VOLTS = 3'd2,
    REG_OFFSET_VOLTS    = 3'd3,
    REG_DUTY_HUNDREDTHS = 3'd4,
    REG_CODES_PER_VOLT  = 3'd5,
    REG_MAX_CODE        = 3'd6
  } cfg_reg_t;

  // waveform modes
  typedef enum logic [1:0] {
    MODE_PULSE = 2'd0,
    MODE_SINE  = 2'd1,
    MODE_SAW   = 2'd2,
    MODE_TRI   = 2'd3
  } wave_mode_t;

  // reset values and limits
  localparam logic [13:0] DUTY_FULL        = 14'd10000;
  localparam logic [13:0] DUTY_RESET       = 14'd5000;
  localparam logic [31:0] CODES_PER_VOLT_RESET = 32'd65536;
  localparam logic [15:0] MAX_CODE_RESET   = 16'd4095;
  localparam logic [ROM_W-1:0] ONE_Q16     = 17'd65536;

  // quarter-wave table build, used at elaboration only
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

  // sin(pi/2 * idx / 2^bits) in Q16 via truncating Q30 series, rounded half up, capped
  function automatic logic [ROM_W-1:0] quarter_sine(input logic [15:0] idx,
                                                    input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rnd;
    x    = ({48'd0, idx} * HALF_PI_Q30) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    rnd = (sum + 64'd8192) >> 14;
    if (rnd > 64'(ONE_Q16)) begin
      rnd = 64'(ONE_Q16);
    end
    return rnd[ROM_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wsg_if.sv
// wsg_if: valid/ready channel interfaces for input beats and result beats
// no dependencies; the field widths are written out in the interfaces themselves
`timescale 1ns / 1ps
`default_nettype none

// input beat: waveform mode and microsecond timestamp
interface wsg_in_if #(parameter int TIME_WIDTH = 48) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic [TIME_WIDTH-1:0] time_us;

  modport source (output valid, output mode, output time_us, input ready);
  modport sink   (input valid, input mode, input time_us, output ready);
endinterface

// result beat: level in Q8.16 volts and converter code
interface wsg_out_if #(parameter int CODE_WIDTH = 16) ();
  logic                  valid;
  logic                  ready;
  logic signed [23:0]    level_volts;
  logic [CODE_WIDTH-1:0] dac_code;

  modport source (output valid, output level_volts, output dac_code, input ready);
  modport sink   (input valid, input level_volts, input dac_code, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wsg_sine_rom.sv
// wsg_sine_rom: quarter-wave sine table, 2^TABLE_BITS + 1 entries, registered read
// depends on wsg_pkg for the entry width and the table build function
`timescale 1ns / 1ps
`default_nettype none

module wsg_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [TABLE_BITS:0]       addr,
  output logic [wsg_pkg::ROM_W-1:0]      data
);
  import wsg_pkg::*;

  localparam int N = 1 << TABLE_BITS;

  logic [ROM_W-1:0] rom_w [N+1];
  logic [ROM_W-1:0] data_r;

  // constant entries, worked out at elaboration
  for (genvar g = 0; g <= N; g++) begin : g_entry
    localparam logic [ROM_W-1:0] ENTRY = quarter_sine(16'(g), TABLE_BITS);
    assign rom_w[g] = ENTRY;
  end

  // registered read, held while the stage stalls
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= rom_w[addr];
    end
  end

  assign data = data_r;

endmodule

`default_nettype wire

>>> hw/rtl/waveform_sample_generator_core.sv
// waveform_sample_generator_core: pipelined pulse/sine/sawtooth/triangle sample generator
// depends on wsg_pkg, wsg_if (channel interfaces) and wsg_sine_rom
//
// Usage:
//  in_ch carries one beat per sample: waveform mode and a microsecond timestamp.
//  out_ch returns one beat per input beat, in order: level in signed Q8.16 volts
//  and the converter code clamped to 0 .. max_code.
//  cfg_we/cfg_index/cfg_data write the seven setup registers; write them only while
//  no beat is in flight. Unknown indexes are ignored, duty writes saturate at 10000.
//  A beat passes from input accept to the result beat on out_ch through eight
//  register stages (phase add, phase multiply, waveform prep, table read, amplitude
//  multiply, offset add, code multiply, clamp), each with its own valid bit.
//  Throughput is one beat per cycle while out_ch does not stall.
//  When out_ch stalls, stages fill toward the output register; in_ch.ready drops only
//  once every stage holds a beat, so nothing is lost or repeated.
//  Reset (rst_n low, synchronous) empties the pipeline and loads register defaults;
//  there is no clearing pass, the sine table is constant.
`timescale 1ns / 1ps
`default_nettype none

module waveform_sample_generator_core #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int TIME_WIDTH      = 48,
  parameter int CODE_WIDTH      = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  wsg_in_if.sink                               in_ch,
  wsg_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [wsg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wsg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wsg_pkg::*;

  localparam int B = SINE_TABLE_BITS;
  localparam logic [B:0] ROM_LAST = (B+1)'(1 << B);

  // configuration registers
  logic [31:0]        step_r;
  logic [31:0]        phase_off_r;
  logic signed [23:0] amp_r;
  logic signed [23:0] offset_r;
  logic [13:0]        duty_r;
  logic [31:0]        cpv_r;
  logic [15:0]        max_code_r;

  // pipeline control
  logic [NSTAGE:1] v_r;
  logic [NSTAGE:1] en;

  // stage payloads
  logic [TIME_WIDTH-1:0]  time_in;
  logic [1:0]             mode1_r, mode2_r, mode3_r, mode4_r;
  logic [31:0]            t1_r;
  logic [31:0]            p2_r;
  logic [31:0]            p_nxt;
  logic                   pulse3_r, pulse4_r;
  logic                   neg3_r, neg4_r;
  logic [15:0]            saw3_r, saw4_r;
  logic [16:0]            tri3_r, tri4_r;
  logic [B:0]             addr3_r;
  logic [ROM_W-1:0]       rom_data;
  logic signed [WAVE_W-1:0] wave;
  logic signed [41:0]     prod5_r;
  logic signed [23:0]     level6_r, level7_r, level8_r;
  logic signed [56:0]     dac7_r;
  logic [CODE_WIDTH-1:0]  code8_r;

  // stage 3 helpers
  logic [45:0]            pulse_lhs;
  logic [B-1:0]           idx;
  logic [33:0]            tri_full;

  // stage 8 helpers
  logic [CODE_WIDTH-1:0]  mc;
  logic [24:0]            dac_hi;
  logic                   over;
  logic [CODE_WIDTH-1:0]  code_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      phase_off_r <= '0;
      amp_r       <= '0;
      offset_r    <= '0;
      duty_r      <= DUTY_RESET;
      cpv_r       <= CODES_PER_VOLT_RESET;
      max_code_r  <= MAX_CODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PHASE_STEP:      step_r      <= cfg_data;
        REG_PHASE_OFFSET_US: phase_off_r <= cfg_data;
        REG_AMPLITUDE_VOLTS: amp_r       <= cfg_data[23:0];
        REG_OFFSET_VOLTS:    offset_r    <= cfg_data[23:0];
        REG_DUTY_HUNDREDTHS: duty_r      <= (cfg_data[13:0] > DUTY_FULL) ? DUTY_FULL
                                                                         : cfg_data[13:0];
        REG_CODES_PER_VOLT:  cpv_r       <= cfg_data;
        REG_MAX_CODE:        max_code_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NSTAGE] = !v_r[NSTAGE] || out_ch.ready;
    for (int s = NSTAGE - 1; s >= 1; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign in_ch.ready = en[1];

  // valid bits travel with the beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_ch.valid;
      end
      for (int s = 2; s <= NSTAGE; s++) begin
        if (en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // stage 1: timestamp plus phase offset, modulo 2^32
  assign time_in = in_ch.time_us;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t1_r    <= time_in[31:0] + phase_off_r;
      mode1_r <= in_ch.mode;
    end
  end

  // stage 2: phase = t * step, low 32 bits
  assign p_nxt = t1_r * step_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p2_r    <= p_nxt;
      mode2_r <= mode1_r;
    end
  end

  // stage 3: pulse compare, sawtooth, triangle and table address
  assign pulse_lhs = 46'(p2_r) * 46'(DUTY_FULL);
  assign idx       = p2_r[29 -: B];
  assign tri_full  = p2_r[31] ? (34'h2_0000_0000 - {1'b0, p2_r, 1'b0})
                              : {1'b0, p2_r, 1'b0};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pulse3_r <= pulse_lhs < {duty_r, 32'd0};
      saw3_r   <= p2_r[31:16];
      tri3_r   <= tri_full[32:16];
      neg3_r   <= p2_r[31];
      addr3_r  <= p2_r[30] ? (ROM_LAST - {1'b0, idx}) : {1'b0, idx};
      mode3_r  <= mode2_r;
    end
  end

  // stage 4: quarter-wave table read
  wsg_sine_rom #(
    .TABLE_BITS (B)
  ) u_rom (
    .clk  (clk),
    .en   (en[4]),
    .addr (addr3_r),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (en[4]) begin
      pulse4_r <= pulse3_r;
      saw4_r   <= saw3_r;
      tri4_r   <= tri3_r;
      neg4_r   <= neg3_r;
      mode4_r  <= mode3_r;
    end
  end

  // stage 5: waveform select and amplitude multiply
  always_comb begin
    unique case (wave_mode_t'(mode4_r))
      MODE_PULSE: wave = pulse4_r ? $signed({1'b0, ONE_Q16}) : '0;
      MODE_SINE:  wave = neg4_r ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
      MODE_SAW:   wave = $signed({2'b00, saw4_r});
      MODE_TRI:   wave = $signed({1'b0, tri4_r});
      default:    wave = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      prod5_r <= $signed({{18{amp_r[23]}}, amp_r}) * $signed({{24{wave[WAVE_W-1]}}, wave});
    end
  end

  // stage 6: floor divide by 2^16 and add offset, wrapping in 24 bits
  always_ff @(posedge clk) begin
    if (en[6]) begin
      level6_r <= prod5_r[39:16] + offset_r;
    end
  end

  // stage 7: level times codes per volt
  always_ff @(posedge clk) begin
    if (en[7]) begin
      dac7_r   <= $signed({{33{level6_r[23]}}, level6_r}) * $signed({25'd0, cpv_r});
      level7_r <= level6_r;
    end
  end

  // stage 8: clamp into the converter range
  assign mc     = max_code_r[CODE_WIDTH-1:0];
  assign dac_hi = dac7_r[56:32];
  assign over   = (dac_hi > 25'(mc)) || ((dac_hi == 25'(mc)) && (|dac7_r[31:0]));

  always_comb begin
    priority if (dac7_r[56]) begin
      code_nxt = '0;
    end else if (over) begin
      code_nxt = mc - CODE_WIDTH'(1);
    end else begin
      code_nxt = dac7_r[32 +: CODE_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      code8_r  <= code_nxt;
      level8_r <= level7_r;
    end
  end

  // result beat
  assign out_ch.valid       = v_r[NSTAGE];
  assign out_ch.level_volts = level8_r;
  assign out_ch.dac_code    = code8_r;

`ifndef SYNTHESIS
  // input is held off only when every stage holds a beat
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled with an empty stage");

  // a negative level never gives a nonzero code
  a_neg_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.level_volts[23]) |-> (out_ch.dac_code == '0))
    else $error("negative level produced a nonzero code");

  // code never exceeds max_code when max_code is nonzero
  a_code_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (mc != '0)) |-> (out_ch.dac_code <= mc))
    else $error("code above max_code");

  // duty register stays saturated
  a_duty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_we) |-> (duty_r <= DUTY_FULL))
    else $error("duty register above full scale");
`endif

endmodule

`default_nettype wire
